### hw/rtl/multi_sensor_sliding_median_unit_macros.svh
// Assertion macros for the sliding median unit.
`ifndef MULTI_SENSOR_SLIDING_MEDIAN_UNIT_MACROS_SVH
`define MULTI_SENSOR_SLIDING_MEDIAN_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define MSSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define MSSM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define MSSM_ASSERT(lbl, prop, msg)
`define MSSM_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### hw/rtl/mssm_pkg.sv
// Shared types and constants for the sliding median unit.
package mssm_pkg;

    localparam int DIST_W   = 16;
    localparam int SEL_IN_W = 2;

    typedef logic [DIST_W-1:0]   dist_t;
    typedef logic [SEL_IN_W-1:0] sel_in_t;

    // 9999 cm in quarter centimeters
    localparam dist_t RESET_QCM = 16'd39996;

endpackage

### hw/rtl/multi_sensor_sliding_median_unit.sv
// Sliding-window median filter with one history ring per sensor.
// Candidates are tried newest first through S_LOAD, S_SCAN and S_DECIDE until one is the median (1..WINDOW tried).
// Each candidate is one memory read plus WINDOW reads and compares on the shared less-than and equal compares.
// s_tready is low while an item is in work; a new item is taken only after the last result is issued.
// Reset: pointers and fill flags clear, so every ring reads as 39996 until written.
// No clearing pass after reset; the unit is ready on the first cycle out of reset.
`include "multi_sensor_sliding_median_unit_macros.svh"

module multi_sensor_sliding_median_unit
    import mssm_pkg::*;
#(
    parameter int SENSORS       = 3,
    parameter int HISTORY_DEPTH = 8,
    parameter int WINDOW        = 5
) (
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [15:0]   s_tdata,   // [15:0] raw_distance
    input  logic [1:0]    s_tuser,   // [1:0] sensor_sel

    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata,   // [15:0] median_distance
    output logic [1:0]    m_tuser    // [1:0] out_sensor
);

    localparam int ENTRIES = SENSORS * HISTORY_DEPTH;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IDX_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SEL_W   = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam logic [CNT_W-1:0] RANK_K  = CNT_W'(WINDOW / 2);
    localparam logic [CNT_W-1:0] WIN_N   = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0] LAST_I  = CNT_W'(WINDOW - 1);
    localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(HISTORY_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_DECIDE,
        S_OUT
    } state_t;

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] v);
        return (v == '0) ? LAST_IX : v - 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [SEL_W-1:0] s,
                                                   input logic [IDX_W-1:0] i);
        return ADDR_W'(ADDR_W'(s) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(i));
    endfunction

    dist_t ring_mem [ENTRIES];

    state_t                 state_reg,    state_next;
    sel_in_t                sel_reg,      sel_next;
    logic [IDX_W-1:0]       ptr_reg  [SENSORS];
    logic [IDX_W-1:0]       ptr_next [SENSORS];
    logic                   full_reg [SENSORS];
    logic                   full_next[SENSORS];
    logic [IDX_W-1:0]       newest_reg,   newest_next;
    logic [IDX_W-1:0]       cand_idx_reg, cand_idx_next;
    logic [IDX_W-1:0]       j_idx_reg,    j_idx_next;
    logic [CNT_W-1:0]       i_cnt_reg,    i_cnt_next;
    logic [CNT_W-1:0]       j_cnt_reg,    j_cnt_next;
    logic [CNT_W-1:0]       less_cnt_reg, less_cnt_next;
    logic [CNT_W-1:0]       leq_cnt_reg,  leq_cnt_next;
    dist_t                  cand_reg,     cand_next;
    logic                   cand_ld_reg,  cand_ld_next;
    logic                   cmp_pend_reg, cmp_pend_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    dist_t                  m_tdata_reg,  m_tdata_next;
    sel_in_t                m_tuser_reg,  m_tuser_next;
    dist_t                  rdata_reg;
    logic                   rd_ok_reg;

    logic [SEL_W-1:0]       in_sel;
    logic [SEL_W-1:0]       cur_sel;
    logic                   wr_en;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_idx;
    dist_t                  rd_value;
    logic                   cmp_lt;
    logic                   cmp_eq;
    logic                   hit;

    assign in_sel   = SEL_W'(s_tuser);
    assign cur_sel  = SEL_W'(sel_reg);
    assign rd_idx   = (state_reg == S_LOAD) ? cand_idx_reg : j_idx_reg;
    assign rd_value = rd_ok_reg ? rdata_reg : RESET_QCM;
    assign cmp_lt   = rd_value < cand_reg;
    assign cmp_eq   = rd_value == cand_reg;
    assign hit      = (less_cnt_reg <= RANK_K) && (leq_cnt_reg > RANK_K);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        ptr_next      = ptr_reg;
        full_next     = full_reg;
        newest_next   = newest_reg;
        cand_idx_next = cand_idx_reg;
        j_idx_next    = j_idx_reg;
        i_cnt_next    = i_cnt_reg;
        j_cnt_next    = j_cnt_reg;
        less_cnt_next = less_cnt_reg;
        leq_cnt_next  = leq_cnt_reg;
        cand_next     = cand_reg;
        cand_ld_next  = 1'b0;
        cmp_pend_next = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;

        if (cand_ld_reg) begin
            cand_next = rd_value;
        end

        case (state_reg)
            S_IDLE: begin
                // out-of-range sensor: item is taken and dropped
                if (s_tvalid && (32'(s_tuser) < SENSORS)) begin
                    wr_en             = 1'b1;
                    sel_next          = s_tuser;
                    newest_next       = ptr_reg[in_sel];
                    cand_idx_next     = ptr_reg[in_sel];
                    i_cnt_next        = '0;
                    if (ptr_reg[in_sel] == LAST_IX) begin
                        ptr_next[in_sel]  = '0;
                        full_next[in_sel] = 1'b1;
                    end else begin
                        ptr_next[in_sel] = ptr_reg[in_sel] + 1'b1;
                    end
                    state_next        = S_LOAD;
                end
            end
            S_LOAD: begin
                rd_en         = 1'b1;
                cand_ld_next  = 1'b1;
                j_cnt_next    = '0;
                j_idx_next    = newest_reg;
                less_cnt_next = '0;
                leq_cnt_next  = '0;
                state_next    = S_SCAN;
            end
            S_SCAN: begin
                if (cmp_pend_reg) begin
                    less_cnt_next = less_cnt_reg + CNT_W'(cmp_lt);
                    leq_cnt_next  = leq_cnt_reg + CNT_W'(cmp_lt || cmp_eq);
                end
                if (j_cnt_reg < WIN_N) begin
                    rd_en         = 1'b1;
                    cmp_pend_next = 1'b1;
                    j_cnt_next    = j_cnt_reg + 1'b1;
                    j_idx_next    = idx_dec(j_idx_reg);
                end else begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (hit) begin
                    state_next = S_OUT;
                end else begin
                    i_cnt_next    = i_cnt_reg + 1'b1;
                    cand_idx_next = idx_dec(cand_idx_reg);
                    state_next    = S_LOAD;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = cand_reg;
                    m_tuser_next  = sel_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cand_ld_reg  <= 1'b0;
            cmp_pend_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int s = 0; s < SENSORS; s++) begin
                ptr_reg[s]  <= '0;
                full_reg[s] <= 1'b0;
            end
        end else begin
            state_reg    <= state_next;
            cand_ld_reg  <= cand_ld_next;
            cmp_pend_reg <= cmp_pend_next;
            m_tvalid_reg <= m_tvalid_next;
            ptr_reg      <= ptr_next;
            full_reg     <= full_next;
        end
        sel_reg      <= sel_next;
        newest_reg   <= newest_next;
        cand_idx_reg <= cand_idx_next;
        j_idx_reg    <= j_idx_next;
        i_cnt_reg    <= i_cnt_next;
        j_cnt_reg    <= j_cnt_next;
        less_cnt_reg <= less_cnt_next;
        leq_cnt_reg  <= leq_cnt_next;
        cand_reg     <= cand_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    // ring storage: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[mem_addr(in_sel, ptr_reg[in_sel])] <= s_tdata;
        end
        if (rd_en) begin
            rdata_reg <= ring_mem[mem_addr(cur_sel, rd_idx)];
            rd_ok_reg <= full_reg[cur_sel] || (rd_idx < ptr_reg[cur_sel]);
        end
    end

    `MSSM_ASSERT(a_busy_after_accept, (s_tvalid && s_tready && (32'(s_tuser) < SENSORS)) |=> !s_tready, "unit ready right after taking an item")
    `MSSM_ASSERT(a_last_cand_hits, (state_reg == S_DECIDE && i_cnt_reg == LAST_I) |-> hit, "no median found in window")
    `MSSM_ASSERT(a_rank_order, (state_reg == S_DECIDE) |-> (leq_cnt_reg > less_cnt_reg), "candidate not counted against itself")
    `MSSM_ASSERT(a_out_from_seq, $rose(m_tvalid) |-> $past(state_reg == S_OUT), "result raised outside output step")
    `MSSM_ASSERT_RST(a_reset_clears, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule
